### rtl/tmlcs_pkg.sv
// tmlcs_pkg: widths, defaults, register indexes and shared structs for the
// turntable capture sequencer; no dependencies, compiled first
`default_nettype none

package tmlcs_pkg;

  // field widths
  localparam int KIND_W     = 2;
  localparam int LED_W      = 3;
  localparam int ANGLE_W    = 10;
  localparam int STEP_W     = 9;
  localparam int IVAL_W     = 16;
  localparam int EXP_W      = 16;
  localparam int MARGIN_W   = 10;
  localparam int COUNT_W    = 16;

  // derived timing widths
  localparam int IV_W       = 17;  // exposure + 3*margin fits here
  localparam int SCLK_W     = 17;  // shot clock never passes exposure + 2*margin
  localparam int BCLK_W     = 19;  // burst clock never passes 7 intervals

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_MARGIN    = 2'd3;

  // event codes carried in the kind field of an input word
  typedef enum logic [KIND_W-1:0] {
    KIND_TICK   = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_HOMED  = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  // register reset values
  localparam logic [STEP_W-1:0]   ANGLE_STEP_RST    = 9'd10;
  localparam logic [IVAL_W-1:0]   SHOT_INTERVAL_RST = 16'd500;
  localparam logic [EXP_W-1:0]    EXPOSURE_RST      = 16'd100;
  localparam logic [MARGIN_W-1:0] LED_MARGIN_RST    = 10'd10;

  // parameter defaults
  localparam int LED_COUNT_DEF   = 5;
  localparam int ANGLE_LIMIT_DEF = 355;

  // per-shot thresholds on the shot clock
  typedef struct packed {
    logic [SCLK_W-1:0] trig_on;   // margin
    logic [SCLK_W-1:0] trig_off;  // exposure + margin
    logic [SCLK_W-1:0] shot_end;  // exposure + 2*margin
  } timing_t;

  // one result word
  typedef struct packed {
    logic [LED_W-1:0]   led_on;
    logic               focus;
    logic               trigger;
    logic [ANGLE_W-1:0] angle_command;
    logic               angle_valid;
    logic               home_request;
    logic               sequence_active;
    logic [COUNT_W-1:0] shots_taken;
  } result_t;

endpackage

`default_nettype wire

### rtl/tmlcs_in_if.sv
// tmlcs_in_if: input word channel (event kind and motor status)
// depends on tmlcs_pkg
`default_nettype none

interface tmlcs_in_if;
  import tmlcs_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic              motor_at_target;

  modport source (output valid, output kind, output motor_at_target, input ready);
  modport sink   (input valid, input kind, input motor_at_target, output ready);
endinterface

`default_nettype wire

### rtl/tmlcs_out_if.sv
// tmlcs_out_if: result word channel (lamp, camera and stepper outputs)
// depends on tmlcs_pkg
`default_nettype none

interface tmlcs_out_if;
  import tmlcs_pkg::*;

  logic               valid;
  logic               ready;
  logic [LED_W-1:0]   led_on;
  logic               focus;
  logic               trigger;
  logic [ANGLE_W-1:0] angle_command;
  logic               angle_valid;
  logic               home_request;
  logic               sequence_active;
  logic [COUNT_W-1:0] shots_taken;

  modport source (output valid, output led_on, output focus, output trigger,
                  output angle_command, output angle_valid, output home_request,
                  output sequence_active, output shots_taken, input ready);
  modport sink   (input valid, input led_on, input focus, input trigger,
                  input angle_command, input angle_valid, input home_request,
                  input sequence_active, input shots_taken, output ready);
endinterface

`default_nettype wire

### rtl/tmlcs_seq.sv
// tmlcs_seq: sequencer state, burst timer and shot timer; one step per word
// depends on tmlcs_pkg
`default_nettype none

module tmlcs_seq #(
  parameter int LED_COUNT   = tmlcs_pkg::LED_COUNT_DEF,
  parameter int ANGLE_LIMIT = tmlcs_pkg::ANGLE_LIMIT_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               step,
  input  wire logic [tmlcs_pkg::KIND_W-1:0]       kind,
  input  wire logic                               at_target,
  input  wire logic [tmlcs_pkg::STEP_W-1:0]       angle_step,
  input  wire tmlcs_pkg::timing_t                 tm,
  input  wire logic [LED_COUNT:0][tmlcs_pkg::BCLK_W-1:0] burst_thr,
  output tmlcs_pkg::result_t                      res
);
  import tmlcs_pkg::*;

  typedef enum logic [1:0] {
    HOME_NONE,
    HOME_BUSY,
    HOME_DONE
  } home_t;

  typedef enum logic [2:0] {
    PH_STANDBY,
    PH_START_BURST,
    PH_ROTATE_CMD,
    PH_BURST_BUSY,
    PH_ROTATE_BUSY
  } phase_t;

  logic               seq_en_r,      seq_en_nxt;
  home_t              home_r,        home_nxt;
  phase_t             phase_r,       phase_nxt;
  logic               first_r,       first_nxt;
  logic [ANGLE_W-1:0] angle_r,       angle_nxt;
  logic               burst_run_r,   burst_run_nxt;
  logic [BCLK_W-1:0]  burst_clk_r,   burst_clk_nxt;
  logic               shot_run_r,    shot_run_nxt;
  logic [SCLK_W-1:0]  shot_clk_r,    shot_clk_nxt;
  logic [LED_W-1:0]   led_r,         led_nxt;
  logic               focus_r,       focus_nxt;
  logic               trig_r,        trig_nxt;
  logic [COUNT_W-1:0] count_r,       count_nxt;

  logic [ANGLE_W-1:0] ang_cmd;
  logic               ang_valid;
  logic               home_req;
  logic               hit;
  logic [LED_W-1:0]   hit_led;

  always_comb begin
    seq_en_nxt    = seq_en_r;
    home_nxt      = home_r;
    phase_nxt     = phase_r;
    first_nxt     = first_r;
    angle_nxt     = angle_r;
    burst_run_nxt = burst_run_r;
    burst_clk_nxt = burst_clk_r;
    shot_run_nxt  = shot_run_r;
    shot_clk_nxt  = shot_clk_r;
    led_nxt       = led_r;
    focus_nxt     = focus_r;
    trig_nxt      = trig_r;
    count_nxt     = count_r;
    ang_cmd       = '0;
    ang_valid     = 1'b0;
    home_req      = 1'b0;
    hit           = 1'b0;
    hit_led       = '0;

    unique case (kind)
      KIND_TOGGLE: begin
        if (!seq_en_r) begin
          seq_en_nxt = 1'b1;
          first_nxt  = 1'b1;
          count_nxt  = '0;
          home_nxt   = HOME_NONE;
        end else begin
          // stop aborts everything with all lamp and camera lines off
          seq_en_nxt    = 1'b0;
          burst_run_nxt = 1'b0;
          burst_clk_nxt = '0;
          shot_run_nxt  = 1'b0;
          shot_clk_nxt  = '0;
          led_nxt       = '0;
          focus_nxt     = 1'b0;
          trig_nxt      = 1'b0;
          phase_nxt     = PH_STANDBY;
        end
      end
      KIND_HOMED: begin
        if (home_r == HOME_BUSY) home_nxt = HOME_DONE;
      end
      KIND_TICK: begin
        // sequence control
        if (seq_en_r) begin
          if (home_r == HOME_DONE) begin
            if (first_r) begin
              first_nxt = 1'b0;
              angle_nxt = ANGLE_W'(angle_step);
              count_nxt = '0;
              phase_nxt = PH_START_BURST;
            end
            unique case (phase_nxt)
              PH_START_BURST: begin
                burst_clk_nxt = '0;
                burst_run_nxt = 1'b1;
                phase_nxt     = PH_BURST_BUSY;
              end
              PH_ROTATE_CMD: begin
                ang_cmd   = angle_nxt;
                ang_valid = 1'b1;
                if (angle_nxt > ANGLE_W'(ANGLE_LIMIT)) begin
                  seq_en_nxt = 1'b0;
                  phase_nxt  = PH_STANDBY;
                  home_req   = 1'b1;
                  angle_nxt  = '0;
                end else begin
                  angle_nxt = angle_nxt + ANGLE_W'(angle_step);
                  phase_nxt = PH_ROTATE_BUSY;
                end
              end
              PH_ROTATE_BUSY: begin
                if (at_target) phase_nxt = PH_START_BURST;
              end
              default: ;
            endcase
          end else if (home_r == HOME_NONE) begin
            home_req = 1'b1;
            home_nxt = HOME_BUSY;
          end
        end

        // burst timer: lowest matching shot start wins
        if (burst_run_nxt) begin
          for (int k = LED_COUNT - 1; k >= 0; k--) begin
            if (burst_clk_nxt == burst_thr[k]) begin
              hit     = 1'b1;
              hit_led = LED_W'(k + 1);
            end
          end
          if (hit) begin
            led_nxt      = hit_led;
            shot_run_nxt = 1'b1;
            shot_clk_nxt = '0;
          end
          if (burst_clk_nxt >= burst_thr[LED_COUNT]) begin
            burst_run_nxt = 1'b0;
            burst_clk_nxt = '0;
            phase_nxt     = PH_ROTATE_CMD;
          end else begin
            burst_clk_nxt = burst_clk_nxt + 1'b1;
          end
        end

        // shot timer
        if (shot_run_nxt) begin
          if (shot_clk_nxt == '0) focus_nxt = 1'b1;
          if (shot_clk_nxt == tm.trig_on) begin
            trig_nxt  = 1'b1;
            count_nxt = count_nxt + 1'b1;
          end
          if (shot_clk_nxt == tm.trig_off) begin
            trig_nxt  = 1'b0;
            focus_nxt = 1'b0;
          end
          if (shot_clk_nxt >= tm.shot_end) begin
            shot_run_nxt = 1'b0;
            shot_clk_nxt = '0;
            led_nxt      = '0;
          end else begin
            shot_clk_nxt = shot_clk_nxt + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.led_on          = led_nxt;
    res.focus           = focus_nxt;
    res.trigger         = trig_nxt;
    res.angle_command   = ang_cmd;
    res.angle_valid     = ang_valid;
    res.home_request    = home_req;
    res.sequence_active = seq_en_nxt;
    res.shots_taken     = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_en_r    <= 1'b0;
      home_r      <= HOME_NONE;
      phase_r     <= PH_STANDBY;
      first_r     <= 1'b0;
      angle_r     <= '0;
      burst_run_r <= 1'b0;
      burst_clk_r <= '0;
      shot_run_r  <= 1'b0;
      shot_clk_r  <= '0;
      led_r       <= '0;
      focus_r     <= 1'b0;
      trig_r      <= 1'b0;
      count_r     <= '0;
    end else if (step) begin
      seq_en_r    <= seq_en_nxt;
      home_r      <= home_nxt;
      phase_r     <= phase_nxt;
      first_r     <= first_nxt;
      angle_r     <= angle_nxt;
      burst_run_r <= burst_run_nxt;
      burst_clk_r <= burst_clk_nxt;
      shot_run_r  <= shot_run_nxt;
      shot_clk_r  <= shot_clk_nxt;
      led_r       <= led_nxt;
      focus_r     <= focus_nxt;
      trig_r      <= trig_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/turntable_multi_light_capture_sequencer_core.sv
// turntable_multi_light_capture_sequencer_core: top level with channel
// handshakes, configuration registers and derived timing; uses tmlcs_pkg,
// tmlcs_in_if, tmlcs_out_if and tmlcs_seq
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        kind, motor_at_target
//   out_ch    out  valid/ready        led_on .. shots_taken (one word per input)
//   cfg_*     in   cfg_we, no ready   cfg_index, cfg_data
//
// each input word is registered in the input register, then the sequencer
// step runs and the result lands in the output register; one word per cycle
// sustained while out_ch is ready and no config write holds off in_ch
// the output register stalls the step while it holds a word and out_ch is
// not ready; the input register refills in the same cycle the step fires
// timing thresholds are registered in two stages behind the config registers,
// so in_ch.ready drops on a config write and stays low until both stages have
// caught up, and likewise after reset
// synchronous active-low reset clears the sequencer state and both valid bits
`default_nettype none

module turntable_multi_light_capture_sequencer_core #(
  parameter int LED_COUNT   = tmlcs_pkg::LED_COUNT_DEF,
  parameter int ANGLE_LIMIT = tmlcs_pkg::ANGLE_LIMIT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  tmlcs_in_if.sink                              in_ch,
  tmlcs_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [tmlcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tmlcs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmlcs_pkg::*;

  // configuration registers
  logic [STEP_W-1:0]   angle_step_r;
  logic [IVAL_W-1:0]   interval_r;
  logic [EXP_W-1:0]    exposure_r;
  logic [MARGIN_W-1:0] margin_r;

  // derived timing: stage one gives the effective interval and shot
  // thresholds, stage two the shot start times of the burst
  logic [IV_W-1:0]   iv_r, iv_nxt;
  timing_t           tm_r, tm_nxt;
  logic [LED_COUNT:0][BCLK_W-1:0] thr_r, thr_nxt;
  logic [1:0]        hold_r;

  // word path
  logic              in_v_r;
  logic [KIND_W-1:0] kind_r;
  logic              at_tgt_r;
  logic              out_v_r;
  result_t           out_r;
  result_t           res;
  logic              fire;
  logic              in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_step_r <= ANGLE_STEP_RST;
      interval_r   <= SHOT_INTERVAL_RST;
      exposure_r   <= EXPOSURE_RST;
      margin_r     <= LED_MARGIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ANGLE_STEP:    angle_step_r <= cfg_data[STEP_W-1:0];
        CFG_SHOT_INTERVAL: interval_r   <= cfg_data[IVAL_W-1:0];
        CFG_EXPOSURE:      exposure_r   <= cfg_data[EXP_W-1:0];
        CFG_LED_MARGIN:    margin_r     <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [IV_W-1:0] floor_v;
    floor_v = IV_W'(exposure_r) + IV_W'(margin_r) + IV_W'({margin_r, 1'b0});
    // interval is never shorter than exposure plus three margins
    iv_nxt  = (IV_W'(interval_r) > floor_v) ? IV_W'(interval_r) : floor_v;
    tm_nxt.trig_on  = SCLK_W'(margin_r);
    tm_nxt.trig_off = SCLK_W'(exposure_r) + SCLK_W'(margin_r);
    tm_nxt.shot_end = SCLK_W'(exposure_r) + SCLK_W'({margin_r, 1'b0});
  end

  always_comb begin
    for (int k = 0; k <= LED_COUNT; k++) begin
      thr_nxt[k] = BCLK_W'(k * int'(iv_r));
    end
  end

  always_ff @(posedge clk) begin
    iv_r  <= iv_nxt;
    tm_r  <= tm_nxt;
    thr_r <= thr_nxt;
  end

  // hold off input words until the timing stages have caught up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 2'd2;
    end else if (cfg_we) begin
      hold_r <= 2'd2;
    end else if (hold_r != 2'd0) begin
      hold_r <= hold_r - 2'd1;
    end
  end

  // step fires when a word is waiting and the output slot is free or draining
  assign fire   = in_v_r && (!out_v_r || out_ch.ready);
  assign in_rdy = !cfg_we && (hold_r == 2'd0) && (!in_v_r || fire);
  assign in_ch.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_rdy) begin
      in_v_r <= in_ch.valid;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      kind_r   <= in_ch.kind;
      at_tgt_r <= in_ch.motor_at_target;
    end
  end

  tmlcs_seq #(
    .LED_COUNT   (LED_COUNT),
    .ANGLE_LIMIT (ANGLE_LIMIT)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (fire),
    .kind       (kind_r),
    .at_target  (at_tgt_r),
    .angle_step (angle_step_r),
    .tm         (tm_r),
    .burst_thr  (thr_r),
    .res        (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_r <= res;
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.led_on          = out_r.led_on;
  assign out_ch.focus           = out_r.focus;
  assign out_ch.trigger         = out_r.trigger;
  assign out_ch.angle_command   = out_r.angle_command;
  assign out_ch.angle_valid     = out_r.angle_valid;
  assign out_ch.home_request    = out_r.home_request;
  assign out_ch.sequence_active = out_r.sequence_active;
  assign out_ch.shots_taken     = out_r.shots_taken;

endmodule

`default_nettype wire
